@@ hdl/bamr_pkg.sv @@
// shared types, constants and arithmetic helpers for the body-axis matrix rotator
// no dependencies
package bamr_pkg;

    // axis codes carried in tuser
    localparam logic [1:0] KIND_ROLL  = 2'd0;
    localparam logic [1:0] KIND_YAW   = 2'd1;
    localparam logic [1:0] KIND_PITCH = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam int ZW = 33;   // q30 operand width, covers -4.0 <= x < 4.0
    localparam int PW = 67;   // product / sum width

    localparam logic signed [34:0] Q_PI      = 35'sd3373259426;
    localparam logic signed [34:0] Q_HALF_PI = 35'sd1686629713;
    localparam logic signed [ZW-1:0] Q_ONE   = 33'sd1073741824;

    localparam int TERMS_SIN = 5;
    localparam int TERMS_ALL = 11;

    typedef struct packed {
        logic [1:0]           kind;
        logic                 flip;
        logic signed [ZW-1:0] z;
    } rot_t;

    // n / d for n below 2^32 is ((n >> pre) * mul) >> post: the even factor of d is
    // shifted out first, mul is the rounded-up reciprocal of the odd part
    typedef struct packed {
        logic [1:0]  pre;
        logic [31:0] mul;
        logic [5:0]  post;
    } div_t;

    // horner divisors, sine terms then cosine terms
    function automatic div_t div_const(input logic [3:0] step);
        div_t d;
        case (step)
            4'd0:    d = '{2'd1, 32'(((64'd1 << 37) + 64'd54) / 64'd55), 6'd37};
            4'd1:    d = '{2'd3, 32'(((64'd1 << 35) + 64'd8) / 64'd9), 6'd35};
            4'd2:    d = '{2'd1, 32'(((64'd1 << 36) + 64'd20) / 64'd21), 6'd36};
            4'd3:    d = '{2'd2, 32'(((64'd1 << 34) + 64'd4) / 64'd5), 6'd34};
            4'd4:    d = '{2'd1, 32'(((64'd1 << 33) + 64'd2) / 64'd3), 6'd33};
            4'd5:    d = '{2'd2, 32'(((64'd1 << 37) + 64'd32) / 64'd33), 6'd37};
            4'd6:    d = '{2'd1, 32'(((64'd1 << 37) + 64'd44) / 64'd45), 6'd37};
            4'd7:    d = '{2'd3, 32'(((64'd1 << 34) + 64'd6) / 64'd7), 6'd34};
            4'd8:    d = '{2'd1, 32'(((64'd1 << 35) + 64'd14) / 64'd15), 6'd35};
            4'd9:    d = '{2'd2, 32'(((64'd1 << 33) + 64'd2) / 64'd3), 6'd33};
            4'd10:   d = '{2'd1, 32'(64'd1 << 31), 6'd31};
            default: d = '{2'd0, 32'(64'd1 << 31), 6'd31};
        endcase
        return d;
    endfunction

    // divide by 2^30, round to nearest, ties away from zero
    function automatic logic signed [PW-1:0] rnd_q30(input logic signed [PW-1:0] p);
        logic [PW-1:0] mag;
        logic [PW-1:0] r;
        mag = p[PW-1] ? PW'(-p) : PW'(p);
        r   = (mag + (PW'(1) << 29)) >> 30;
        return p[PW-1] ? -$signed(r) : $signed(r);
    endfunction

endpackage

@@ hdl/body_axis_matrix_rotator_unit.sv @@
// rotates a held 3x3 orientation matrix about roll, yaw or pitch, one beat out per beat in
// one item is in flight in the engine at a time, and it takes no new rotation until it is through
// with the last; its steps on the shared 33x33 multiplier are 11 series terms, the sine product,
// the three row updates, and load, x^2 and output; axis code 3 goes from load straight to output
// a two-entry queue keeps taking beats until both entries are full while the engine works or the output waits
// rst_n (async, low) restores the identity matrix and empties queue and output
module body_axis_matrix_rotator_unit #(
    parameter int ENTRY_WIDTH = 18,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  logic [((ANGLE_WIDTH + 7) / 8) * 8 - 1:0]   s_axis_tdata,  // angle
    input  logic [1:0]                                 s_axis_tuser,  // kind
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // e11, e12, e13, e21, e22, e23, e31, e32, e33
    output logic [((9 * ENTRY_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata
);
    import bamr_pkg::*;

    localparam int OW = ((9 * ENTRY_WIDTH + 7) / 8) * 8;

    logic                     push, q_full, q_pop, q_valid;
    rot_t                     wr_entry, rd_entry;
    logic [9*ENTRY_WIDTH-1:0] mat_data;

    bamr_front #(.AW(ANGLE_WIDTH)) u_front (
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .kind     (s_axis_tuser),
        .angle    ($signed(s_axis_tdata[ANGLE_WIDTH-1:0])),
        .push     (push),
        .entry    (wr_entry),
        .q_full   (q_full)
    );

    bamr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .rd_entry (rd_entry)
    );

    bamr_back #(.EW(ENTRY_WIDTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (rd_entry),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (mat_data)
    );

    assign m_axis_tdata = OW'(mat_data);

endmodule

@@ hdl/bamr_front.sv @@
// front end: takes an axis/angle beat, scales the angle to q30 and folds it into +-pi/2
// depends on bamr_pkg
module bamr_front #(
    parameter int AW = 16
) (
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             kind,
    input  logic signed [AW-1:0]   angle,
    output logic                   push,
    output bamr_pkg::rot_t         entry,
    input  logic                   q_full
);
    import bamr_pkg::*;

    logic signed [34:0] z_wide;
    logic signed [34:0] z_fold;
    logic               flip;

    always_comb
    begin
        z_wide = 35'(angle) <<< (33 - AW);
        flip   = 1'b0;
        z_fold = z_wide;
        if (z_wide > Q_HALF_PI)
        begin
            z_fold = z_wide - Q_PI;
            flip   = 1'b1;
        end
        else if (z_wide < -Q_HALF_PI)
        begin
            z_fold = z_wide + Q_PI;
            flip   = 1'b1;
        end
    end

    assign in_ready   = !q_full;
    assign push       = in_valid && !q_full;
    assign entry.kind = kind;
    assign entry.flip = flip;
    assign entry.z    = z_fold[ZW-1:0];

endmodule

@@ hdl/bamr_queue.sv @@
// two-entry queue between the front end and the rotation engine
// depends on bamr_pkg
module bamr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bamr_pkg::rot_t wr_entry,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output bamr_pkg::rot_t rd_entry
);
    import bamr_pkg::*;

    rot_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = count_reg == 2'd2;
    assign valid    = count_reg != 2'd0;
    assign rd_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

@@ hdl/bamr_back.sv @@
// rotation engine: series sine/cosine on a shared multiplier with reciprocal-multiply
// division, then the row-by-row pair update of the held matrix; depends on bamr_pkg
module bamr_back #(
    parameter int EW = 18
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  bamr_pkg::rot_t  q_entry,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [9*EW-1:0] out_data
);
    import bamr_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_X2   = 4'd1;
    localparam logic [3:0] ST_X2R  = 4'd2;
    localparam logic [3:0] ST_TM   = 4'd3;
    localparam logic [3:0] ST_TR   = 4'd4;
    localparam logic [3:0] ST_DM   = 4'd5;
    localparam logic [3:0] ST_SM   = 4'd6;
    localparam logic [3:0] ST_SR   = 4'd7;
    localparam logic [3:0] ST_CEND = 4'd8;
    localparam logic [3:0] ST_E0   = 4'd9;
    localparam logic [3:0] ST_E1   = 4'd10;
    localparam logic [3:0] ST_E2   = 4'd11;
    localparam logic [3:0] ST_E3   = 4'd12;
    localparam logic [3:0] ST_E4   = 4'd13;
    localparam logic [3:0] ST_OUT  = 4'd14;
    localparam logic [3:0] ST_DR   = 4'd15;

    localparam logic signed [PW-1:0] E_HI = (PW'(1) <<< (EW - 1)) - PW'(1);
    localparam logic signed [PW-1:0] E_LO = -(PW'(1) <<< (EW - 1));

    // control
    logic [3:0]      state_reg, state_next;
    logic [3:0]      step_reg, step_next;
    logic [1:0]      row_reg, row_next;
    logic            out_valid_reg, out_valid_next;
    logic signed [EW-1:0] mat_reg [3][3];
    logic signed [EW-1:0] mat_next [3][3];

    // datapath
    logic [1:0]            kind_reg, kind_next;
    logic                  flip_reg, flip_next;
    logic signed [ZW-1:0]  z_reg, z_next;
    logic signed [ZW-1:0]  x2_reg, x2_next;
    logic signed [ZW-1:0]  t_reg, t_next;
    logic signed [ZW-1:0]  s_reg, s_next;
    logic signed [ZW-1:0]  c_reg, c_next;
    logic                  pneg_reg, pneg_next;
    logic [30:0]           dn_reg, dn_next;
    logic signed [PW-1:0]  prod_reg;
    logic signed [PW-1:0]  acc_reg, acc_next;
    logic signed [EW-1:0]  na_reg, na_next;
    logic [9*EW-1:0]       out_data_reg, out_data_next;

    logic signed [ZW-1:0]  mul_a, mul_b;
    logic [1:0]            ca, cb;
    logic signed [EW-1:0]  ea, eb;
    logic signed [PW-1:0]  rp, rs;
    logic [PW-1:0]         pmag;
    div_t                  dv;
    logic [PW-1:0]         quo;
    logic signed [34:0]    qs;
    logic signed [EW-1:0]  nb;

    function automatic logic signed [EW-1:0] sat_e(input logic signed [PW-1:0] v);
        logic signed [EW-1:0] r;
        if (v > E_HI)
            r = E_HI[EW-1:0];
        else if (v < E_LO)
            r = E_LO[EW-1:0];
        else
            r = v[EW-1:0];
        return r;
    endfunction

    assign ca = (kind_reg == KIND_ROLL) ? 2'd1 : 2'd0;
    assign cb = (kind_reg == KIND_PITCH) ? 2'd1 : 2'd2;
    assign ea = mat_reg[0][ca];
    assign eb = mat_reg[0][cb];

    // operand select for the shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_X2:
            begin
                mul_a = z_reg;
                mul_b = z_reg;
            end
            ST_TM:
            begin
                mul_a = x2_reg;
                mul_b = t_reg;
            end
            ST_DM:
            begin
                mul_a = ZW'(dn_reg);
                mul_b = ZW'(dv.mul);
            end
            ST_SM:
            begin
                mul_a = z_reg;
                mul_b = t_reg;
            end
            ST_E0:
            begin
                mul_a = ZW'(ea);
                mul_b = c_reg;
            end
            ST_E1:
            begin
                mul_a = ZW'(eb);
                mul_b = s_reg;
            end
            ST_E2:
            begin
                mul_a = ZW'(eb);
                mul_b = c_reg;
            end
            ST_E3:
            begin
                mul_a = ZW'(ea);
                mul_b = s_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(mul_a * mul_b);
    end

    always_comb
    begin
        rp   = rnd_q30(prod_reg);
        rs   = rnd_q30(acc_reg + prod_reg);
        pmag = rp[PW-1] ? PW'(-rp) : PW'(rp);
        nb   = sat_e(rnd_q30(acc_reg - prod_reg));
        dv   = div_const(step_reg);
        quo  = PW'(prod_reg) >> dv.post;
        qs   = pneg_reg ? -$signed({1'b0, quo[33:0]}) : $signed({1'b0, quo[33:0]});
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg;
        mat_next       = mat_reg;
        kind_next      = kind_reg;
        flip_next      = flip_reg;
        z_next         = z_reg;
        x2_next        = x2_reg;
        t_next         = t_reg;
        s_next         = s_reg;
        c_next         = c_reg;
        pneg_next      = pneg_reg;
        dn_next        = dn_reg;
        acc_next       = acc_reg;
        na_next        = na_reg;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    kind_next = q_entry.kind;
                    flip_next = q_entry.flip;
                    z_next    = q_entry.z;
                    state_next = (q_entry.kind == KIND_NONE) ? ST_OUT : ST_X2;
                end
            end
            ST_X2:
                state_next = ST_X2R;
            ST_X2R:
            begin
                x2_next    = rp[ZW-1:0];
                t_next     = Q_ONE;
                step_next  = 4'd0;
                state_next = ST_TM;
            end
            ST_TM:
                state_next = ST_TR;
            ST_TR:
            begin
                // |x2 * t| stays below 2^32 since |z| <= pi/2 and 0 < t <= 1
                pneg_next  = rp[PW-1];
                dn_next    = 31'(pmag[31:0] >> dv.pre);
                state_next = ST_DM;
            end
            ST_DM:
                state_next = ST_DR;
            ST_DR:
            begin
                t_next    = ZW'(35'(Q_ONE) - qs);
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(TERMS_SIN - 1))
                    state_next = ST_SM;
                else if (step_reg == 4'(TERMS_ALL - 1))
                    state_next = ST_CEND;
                else
                    state_next = ST_TM;
            end
            ST_SM:
                state_next = ST_SR;
            ST_SR:
            begin
                s_next     = rp[ZW-1:0];
                t_next     = Q_ONE;
                state_next = ST_TM;
            end
            ST_CEND:
            begin
                c_next     = flip_reg ? -t_reg : t_reg;
                s_next     = flip_reg ? -s_reg : s_reg;
                row_next   = 2'd0;
                state_next = ST_E0;
            end
            ST_E0:
                state_next = ST_E1;
            ST_E1:
            begin
                acc_next   = prod_reg;
                state_next = ST_E2;
            end
            ST_E2:
            begin
                na_next    = sat_e(rs);
                state_next = ST_E3;
            end
            ST_E3:
            begin
                acc_next   = prod_reg;
                state_next = ST_E4;
            end
            ST_E4:
            begin
                // rows rotate so the working row always sits in slot 0
                mat_next[0]     = mat_reg[1];
                mat_next[1]     = mat_reg[2];
                mat_next[2]     = mat_reg[0];
                mat_next[2][ca] = na_reg;
                mat_next[2][cb] = nb;
                row_next        = row_reg + 2'd1;
                state_next      = (row_reg == 2'd2) ? ST_OUT : ST_E0;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            out_data_next[(r * 3 + k) * EW +: EW] = mat_reg[r][k];
                        end
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 4'd0;
            row_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    mat_reg[r][k] <= (r == k) ? (EW'(1) <<< (EW - 2)) : '0;
                end
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            mat_reg       <= mat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        flip_reg     <= flip_next;
        z_reg        <= z_next;
        x2_reg       <= x2_next;
        t_reg        <= t_next;
        s_reg        <= s_next;
        c_reg        <= c_next;
        pneg_reg     <= pneg_next;
        dn_reg       <= dn_next;
        acc_reg      <= acc_next;
        na_reg       <= na_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ tb/body_axis_matrix_rotator_unit_test.sv @@
// testbench for body_axis_matrix_rotator_unit: directed and random axis/angle beats against an own
// predictor of the held orientation matrix; depends on bamr_pkg and the rtl top level
`timescale 1ns / 1ps

module body_axis_matrix_rotator_unit_test;
    import bamr_pkg::*;

    localparam int EW = 18;
    localparam int AW = 16;
    localparam int DW = ((AW + 7) / 8) * 8;
    localparam int MW = ((9 * EW + 7) / 8) * 8;
    localparam longint QONE = 64'sd1073741824;
    localparam longint QPI = 64'sd3373259426;
    localparam longint QHPI = 64'sd1686629713;

    logic          clk;
    logic          rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata;
    logic [1:0]    s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [MW-1:0] m_axis_tdata;

    typedef logic [9*EW-1:0] matrix_t;

    longint  orient[9];
    matrix_t matrix_q[$];
    int      mismatches;
    bit      failed;
    bit      idle_en;
    bit      hold_off;

    body_axis_matrix_rotator_unit #(.ENTRY_WIDTH(EW), .ANGLE_WIDTH(AW)) u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic longint round_q30(longint p);
        longint m;
        m = (p < 0) ? -p : p;
        m = (m + (64'sd1 <<< 29)) >>> 30;
        return (p < 0) ? -m : m;
    endfunction

    function automatic longint clamp_entry(longint v);
        longint hi;
        hi = (64'sd1 <<< (EW - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic void sin_cos(longint z, output longint s, output longint c);
        longint sd[5];
        longint cd[6];
        longint x2;
        longint t;
        bit     flip;
        sd = '{110, 72, 42, 20, 6};
        cd = '{132, 90, 56, 30, 12, 2};
        flip = 1'b0;
        if (z > QHPI)
        begin
            z = z - QPI;
            flip = 1'b1;
        end
        else if (z < -QHPI)
        begin
            z = z + QPI;
            flip = 1'b1;
        end
        x2 = round_q30(z * z);
        t = QONE;
        for (int k = 0; k < 5; k++)
            t = QONE - round_q30(x2 * t) / sd[k];
        s = round_q30(z * t);
        t = QONE;
        for (int k = 0; k < 6; k++)
            t = QONE - round_q30(x2 * t) / cd[k];
        c = t;
        if (flip)
        begin
            s = -s;
            c = -c;
        end
    endfunction

    // advance the held matrix by one beat and return the packed expected matrix
    function automatic matrix_t rotate_orientation(logic [1:0] kind, logic [AW-1:0] ang);
        longint  s;
        longint  c;
        longint  a;
        longint  b;
        int      ca;
        int      cb;
        matrix_t m;
        if (kind != KIND_NONE)
        begin
            ca = (kind == KIND_ROLL) ? 1 : 0;
            cb = (kind == KIND_PITCH) ? 1 : 2;
            sin_cos(longint'($signed(ang)) * (64'sd1 <<< (33 - AW)), s, c);
            for (int i = 0; i < 3; i++)
            begin
                a = orient[i*3+ca];
                b = orient[i*3+cb];
                orient[i*3+ca] = clamp_entry(round_q30(a * c + b * s));
                orient[i*3+cb] = clamp_entry(round_q30(b * c - a * s));
            end
        end
        for (int i = 0; i < 9; i++)
            m[i*EW +: EW] = orient[i][EW-1:0];
        return m;
    endfunction

    // tvalid stays high after a beat; the next call either reloads it or idles first
    task automatic send_rotation(logic [1:0] kind, logic [AW-1:0] ang);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= DW'(ang);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        matrix_q.push_back(rotate_orientation(kind, ang));
    endtask

    // receiver stalls in bursts, or holds off entirely during the pressure test
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                m_axis_tready <= 1'b0;
            else if (idle_en && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                gap = $urandom_range(1, 7);
                repeat (gap - 1) @(posedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        matrix_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (matrix_q.size() == 0)
            begin
                failed = 1'b1;
                if (mismatches < 10)
                    $display("unexpected beat: %h", m_axis_tdata[9*EW-1:0]);
                mismatches++;
            end
            else
            begin
                want = matrix_q.pop_front();
                for (int i = 0; i < 9; i++)
                    if (m_axis_tdata[i*EW +: EW] !== want[i*EW +: EW])
                    begin
                        failed = 1'b1;
                        if (mismatches < 10)
                            $display("entry e%0d%0d: expected %h got %h", i / 3 + 1,
                                     i % 3 + 1, want[i*EW +: EW], m_axis_tdata[i*EW +: EW]);
                        mismatches++;
                    end
            end
        end
    end

    task automatic test_directed();
        logic [AW-1:0] edges[8];
        edges = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001, 16'hffff,
                  16'h3244, 16'hcdbc, 16'h6488};
        foreach (edges[i])
            for (int k = 0; k < 3; k++)
                send_rotation(k[1:0], edges[i]);
        send_rotation(KIND_NONE, 16'h1234);
    endtask

    task automatic test_random(int count);
        logic [AW-1:0] ang;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 3))
                0:       ang = AW'($urandom);
                1:       ang = AW'($urandom_range(0, 400)) - 16'd200;
                default: ang = AW'($urandom_range(0, 25736)) - 16'd12868;
            endcase
            send_rotation(($urandom_range(0, 15) == 0) ? KIND_NONE : 2'($urandom_range(0, 2)),
                          ang);
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            test_random(8);
            repeat (600) @(posedge clk);
        join_any
        hold_off = 1'b0;
        wait fork;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_ROLL;
        failed = 1'b0;
        mismatches = 0;
        idle_en = 1'b1;
        hold_off = 1'b0;
        for (int i = 0; i < 9; i++)
            orient[i] = (i % 4 == 0) ? (64'sd1 <<< (EW - 2)) : 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(1200);
        idle_en = 1'b0;
        test_random(210);
        s_axis_tvalid <= 1'b0;
        while (matrix_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (!failed)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/bamr_pkg.sv
hdl/bamr_front.sv
hdl/bamr_queue.sv
hdl/bamr_back.sv
hdl/body_axis_matrix_rotator_unit.sv
tb/body_axis_matrix_rotator_unit_test.sv
